### sv/substring_first_match_finder_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring finder check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring finder check failed");

`endif

### sv/sfmf_pkg.sv
`default_nettype none

package sfmf_pkg;

    // Longest needle and the width of the text position counter.
    localparam int NEEDLE_MAX  = 24;
    localparam int OFFSET_BITS = 16;

    localparam int LEN_W       = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_MID  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LEN  = 3'd3;

    localparam logic [LEN_W-1:0] NEEDLE_LEN_RESET = 5'd1;
    localparam logic [LEN_W-1:0] NEEDLE_LEN_MAX   = LEN_W'(NEEDLE_MAX);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // One result item.
    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
    } result_t;

    // Picks needle byte idx out of the packed needle; out of range reads zero.
    function automatic logic [7:0] needle_byte(
        input logic [NEEDLE_MAX*8-1:0] needle,
        input logic [LEN_W-1:0]        idx
    );
        logic [7:0] b;
        b = 8'h00;
        if (idx < NEEDLE_LEN_MAX) begin
            b = needle[idx*8 +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### sv/substring_first_match_finder.sv
// A result enters the output register, or the skid stage while that is full.
// One text byte per cycle until both output stages are full; the cell chain
// compares the whole window in the same cycle as the shift.
// Reset clears the needle to zero bytes with length one, the text position
// and the found flag, and empties the output stages. No clearing pass is needed.
`default_nettype none

module substring_first_match_finder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sfmf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                text_valid,
    output logic                                     text_ready,
    input  wire logic [7:0]                          text_byte,
    input  wire logic                                final_byte,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic                                     match_found,
    output logic [sfmf_pkg::OFFSET_BITS-1:0]         match_offset
);

    localparam int NM = sfmf_pkg::NEEDLE_MAX;
    localparam int LW = sfmf_pkg::LEN_W;
    localparam int OB = sfmf_pkg::OFFSET_BITS;

    logic [sfmf_pkg::CFG_DATA_W-1:0] needle_low_reg;
    logic [sfmf_pkg::CFG_DATA_W-1:0] needle_mid_reg;
    logic [sfmf_pkg::CFG_DATA_W-1:0] needle_high_reg;
    logic [LW-1:0]                   pattern_len_reg;
    logic [NM*8-1:0]                 needle_flat;
    logic [LW-1:0]                   len_eff;

    logic [OB-1:0]     pos_reg;
    logic [OB-1:0]     pos_next;
    logic              found_reg;
    logic              found_next;

    logic              accept;
    logic [7:0]        chain_byte [NM+1];
    logic [NM-1:0]     cell_match;
    logic              all_match;
    logic              enough;
    logic              hit;
    logic [OB-1:0]     len_m1;
    logic [OB-1:0]     start;
    logic              emit;
    sfmf_pkg::result_t res;
    sfmf_pkg::result_t out_res;

    // Configuration writes; the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_mid_reg  <= '0;
            needle_high_reg <= '0;
            pattern_len_reg <= sfmf_pkg::NEEDLE_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfmf_pkg::CFG_NEEDLE_LOW:  needle_low_reg  <= cfg_data;
                sfmf_pkg::CFG_NEEDLE_MID:  needle_mid_reg  <= cfg_data;
                sfmf_pkg::CFG_NEEDLE_HIGH: needle_high_reg <= cfg_data;
                sfmf_pkg::CFG_NEEDLE_LEN:  pattern_len_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    assign needle_flat = {needle_high_reg, needle_mid_reg, needle_low_reg};
    assign len_eff     = (pattern_len_reg > sfmf_pkg::NEEDLE_LEN_MAX) ?
                         sfmf_pkg::NEEDLE_LEN_MAX : pattern_len_reg;

    assign accept = text_valid && text_ready;

    // The window: cell 0 takes the newest byte, each cell feeds the next.
    assign chain_byte[0] = text_byte;

    for (genvar k = 0; k < NM; k++)
    begin : g_cell
        logic          active;
        logic [LW-1:0] idx;

        // Cell k lines up with needle byte len-1-k.
        assign active = (LW'(k) < len_eff);
        assign idx    = len_eff - LW'(k) - LW'(1);

        sfmf_cell u_cell (
            .clk       (clk),
            .shift_en  (accept),
            .byte_in   (chain_byte[k]),
            .needle_in (sfmf_pkg::needle_byte(needle_flat, idx)),
            .active    (active),
            .byte_out  (chain_byte[k+1]),
            .match     (cell_match[k])
        );
    end

    // Match decision for the byte being transferred.
    assign all_match = &cell_match;
    assign len_m1    = OB'(len_eff) - OB'(1);
    assign enough    = (pos_reg >= len_m1);
    assign hit       = (len_eff == '0) ? (pos_reg == '0) : (enough && all_match);
    assign start     = ((len_eff == '0) ? '0 :
                       ((pos_reg == sfmf_pkg::POS_MAX) ? sfmf_pkg::POS_MAX
                                                       : (pos_reg - len_m1)));

    assign emit       = accept && !found_reg && (hit || final_byte);
    assign res.found  = hit;
    assign res.offset = hit ? start : '0;

    // Position and found flag; a final byte starts a new text.
    always_comb
    begin
        pos_next   = pos_reg;
        found_next = found_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                pos_next   = '0;
                found_next = 1'b0;
            end
            else
            begin
                found_next = found_reg || hit;
                if (pos_reg != sfmf_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + OB'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    // Output register and skid stage.
    sfmf_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (emit),
        .push_ready (text_ready),
        .push_data  (res),
        .pop_valid  (result_valid),
        .pop_ready  (result_ready),
        .pop_data   (out_res)
    );

    assign match_found  = out_res.found;
    assign match_offset = out_res.offset;

endmodule

`default_nettype wire

### sv/sfmf_cell.sv
`default_nettype none

// One window cell: holds one text byte, passes it on at every transfer and
// compares the byte arriving from its neighbour with its needle byte.
module sfmf_cell (
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [7:0] byte_in,
    input  wire logic [7:0] needle_in,
    input  wire logic       active,
    output logic      [7:0] byte_out,
    output logic            match
);

    logic [7:0] byte_reg;

    // The window byte needs no reset: it is only compared once written.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    // Compare against the byte that enters this cell on the current shift.
    assign match    = !active || (byte_in == needle_in);
    assign byte_out = byte_reg;

endmodule

`default_nettype wire

### sv/sfmf_out_skid.sv
`default_nettype none

// Output register with a skid stage behind it, so the input side keeps
// running while a result waits on the output.
module sfmf_out_skid (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire sfmf_pkg::result_t push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output sfmf_pkg::result_t     pop_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    sfmf_pkg::result_t out_data_reg;
    sfmf_pkg::result_t out_data_next;
    sfmf_pkg::result_t skid_data_reg;
    sfmf_pkg::result_t skid_data_next;
    logic              pop;

    assign pop = out_valid_reg && pop_ready;

    // Next-state logic for the two stages.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = out_valid_reg;
    assign pop_data   = out_data_reg;

endmodule

`default_nettype wire

### sv/sfmf_checker.sv
`default_nettype none
`include "substring_first_match_finder_macros.svh"

// Port-level checks on the substring finder.
module sfmf_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        text_ready,
    input wire logic                        result_valid,
    input wire logic                        result_ready,
    input wire logic                        match_found,
    input wire logic [sfmf_pkg::OFFSET_BITS-1:0] match_offset
);

    // A stalled result transfer keeps its payload.
    `SFMF_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(match_found) && $stable(match_offset))

    // A not-found result always reports offset zero.
    `SFMF_ASSERT_SAME(a_unmatched_zero, clk, rst_n, result_valid && !match_found, match_offset == '0)

    // The input side only stalls when both output stages are full.
    `SFMF_ASSERT_SAME(a_stall_needs_result, clk, rst_n, !text_ready, result_valid)

endmodule

bind substring_first_match_finder sfmf_checker u_sfmf_checker (.*);

`default_nettype wire
